/* rtl/assert_macros.svh */
// Assertion shorthands for the digest block. Clock and reset are taken from the
// enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold
`define MD5SD_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

// ante implies cons in the same cycle
`define MD5SD_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define MD5SD_IMPLIES_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/md5sd_pkg.sv */
package md5sd_pkg;

   localparam int COUNT_W = 61;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE      = 8'h80;
   localparam logic [5:0] LEN_POS       = 6'd56;
   localparam logic [3:0] LEN_WORD_LO   = 4'd14;
   localparam logic [3:0] LEN_WORD_HI   = 4'd15;
   localparam logic [5:0] LAST_STEP     = 6'd63;
   localparam logic [1:0] LAST_WORD_IDX = 2'd3;

   // block kinds: how the message word is formed from the store
   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_PAD_LEN  = 2'd1;
   localparam logic [1:0] KIND_PAD_ONLY = 2'd2;
   localparam logic [1:0] KIND_LEN_ONLY = 2'd3;

   typedef logic [31:0]       word_type;
   typedef logic [3:0][31:0]  quad_type;

   typedef struct packed {
      logic        wr_en;
      logic [5:0]  wr_pos;
      logic [7:0]  wr_byte;
      logic [3:0]  rd_word;
      logic [1:0]  kind;
      logic [5:0]  pad_pos;
      logic [63:0] bit_len;
   } buf_ctrl_type;

   function automatic word_type md5sd_k(input logic [5:0] i);
      word_type k;
      case (i)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] md5sd_rot(input logic [5:0] i);
      logic [4:0] r;
      case ({i[5:4], i[1:0]})
         4'd0:  r = 5'd7;   4'd1:  r = 5'd12;  4'd2:  r = 5'd17;  4'd3:  r = 5'd22;
         4'd4:  r = 5'd5;   4'd5:  r = 5'd9;   4'd6:  r = 5'd14;  4'd7:  r = 5'd20;
         4'd8:  r = 5'd4;   4'd9:  r = 5'd11;  4'd10: r = 5'd16;  4'd11: r = 5'd23;
         4'd12: r = 5'd6;   4'd13: r = 5'd10;  4'd14: r = 5'd15;  4'd15: r = 5'd21;
         default: r = 5'd7;
      endcase
      return r;
   endfunction

   // message word used by step i, modulo-16 arithmetic on the low nibble
   function automatic logic [3:0] md5sd_msg_index(input logic [5:0] i);
      logic [3:0] t;
      logic [3:0] g;
      t = i[3:0];
      case (i[5:4])
         2'd0:    g = t;
         2'd1:    g = 4'((t << 2) + t + 4'd1);
         2'd2:    g = 4'((t << 1) + t + 4'd5);
         default: g = 4'((t << 3) - t);
      endcase
      return g;
   endfunction

endpackage

/* rtl/md5sd_step.sv */
module md5sd_step
   import md5sd_pkg::*;
(
   input  quad_type   work,
   input  word_type   msg,
   input  logic [5:0] step,
   output quad_type   work_next
);

   word_type   f;
   word_type   sum;
   logic [63:0] dbl;

   always_comb begin
      case (step[5:4])
         2'd0:    f = (work[1] & work[2]) | (~work[1] & work[3]);
         2'd1:    f = (work[1] & work[3]) | (work[2] & ~work[3]);
         2'd2:    f = work[1] ^ work[2] ^ work[3];
         default: f = work[2] ^ (work[1] | ~work[3]);
      endcase
      sum = work[0] + f + md5sd_k(step) + msg;
      // rotate left through a doubled word
      dbl = {sum, sum} << md5sd_rot(step);
      work_next[0] = work[3];
      work_next[1] = work[1] + dbl[63:32];
      work_next[2] = work[1];
      work_next[3] = work[2];
   end

endmodule

/* rtl/md5sd_msgbuf.sv */
module md5sd_msgbuf
   import md5sd_pkg::*;
(
   input  logic         clock,
   input  buf_ctrl_type ctrl,
   output word_type     msg_word
);

   word_type   mem_ff [16];
   word_type   rd_data_ff;
   logic [3:0] rd_word_ff;

   logic [5:0] pos;
   logic [7:0] mem_byte;
   logic [7:0] byte_v;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[ctrl.wr_pos[5:2]][8*ctrl.wr_pos[1:0] +: 8] <= ctrl.wr_byte;
      end
      rd_data_ff <= mem_ff[ctrl.rd_word];
      rd_word_ff <= ctrl.rd_word;
   end

   // overlay padding and length on the stored bytes
   always_comb begin
      msg_word = '0;
      pos      = '0;
      mem_byte = '0;
      byte_v   = '0;
      for (int k = 0; k < 4; k++) begin
         pos      = {rd_word_ff, 2'(k)};
         mem_byte = rd_data_ff[8*k +: 8];
         case (ctrl.kind)
            KIND_DATA: byte_v = mem_byte;
            KIND_PAD_LEN, KIND_PAD_ONLY: begin
               if (pos < ctrl.pad_pos) begin
                  byte_v = mem_byte;
               end else if (pos == ctrl.pad_pos) begin
                  byte_v = PAD_BYTE;
               end else begin
                  byte_v = 8'h00;
               end
            end
            default: byte_v = 8'h00;
         endcase
         msg_word[8*k +: 8] = byte_v;
      end
      if (ctrl.kind == KIND_PAD_LEN || ctrl.kind == KIND_LEN_ONLY) begin
         if (rd_word_ff == LEN_WORD_LO) begin
            msg_word = ctrl.bit_len[31:0];
         end else if (rd_word_ff == LEN_WORD_HI) begin
            msg_word = ctrl.bit_len[63:32];
         end
      end
   end

endmodule

/* rtl/md5_stream_digest.sv */
// MD5 digest over a byte stream. Each request word carries at most one message
// byte and a finish flag; a byte is taken while the block is idle and written
// into a 16 x 32-bit block store. When 64 bytes have gathered, the block runs
// one compression: a setup state starts the first store read, the single step
// unit runs the 64 steps (one MD5 step per cycle, message word read from the
// store one step ahead), and an add state folds the result into the chaining
// words; the request side is not ready throughout. On finish, padding and the
// bit count are overlaid on the store's read data, so one padding compression
// follows (two when 56 or more bytes sit in the last block), after which the
// four digest words are offered on the response side, word 0 first, last_word
// set on word 3. Once word 3 is taken the chaining words and the byte count
// return to their initial values and the next message may start.
`include "assert_macros.svh"

module md5_stream_digest
   import md5sd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_finish,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_STEP = 3'd2;
   localparam logic [2:0] S_ADD  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]         state_ff,    state_in;
   logic [5:0]         step_ff,     step_in;
   logic [1:0]         kind_ff,     kind_in;
   logic               fin_pend_ff, fin_pend_in;
   logic [1:0]         out_idx_ff,  out_idx_in;
   logic [COUNT_W-1:0] count_ff,    count_in;
   quad_type           chain_ff,    chain_in;
   quad_type           work_ff,     work_in;

   logic               req_fire;
   logic               rsp_fire;
   logic [COUNT_W-1:0] count_new;
   quad_type           step_out;
   word_type           msg_word;
   buf_ctrl_type       buf_ctrl;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign rsp_digest_word = chain_ff[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == LAST_WORD_IDX);

   // count after this word's byte, if it carries one
   assign count_new = req_byte_valid ? count_ff + COUNT_W'(1) : count_ff;

   // store port: write the incoming byte, read one step ahead of the step unit
   always_comb begin
      buf_ctrl.wr_en   = req_fire && req_byte_valid;
      buf_ctrl.wr_pos  = count_ff[5:0];
      buf_ctrl.wr_byte = req_data_byte;
      buf_ctrl.rd_word = (state_ff == S_STEP) ? md5sd_msg_index(6'(step_ff + 6'd1))
                                              : md5sd_msg_index(6'd0);
      buf_ctrl.kind    = kind_ff;
      buf_ctrl.pad_pos = count_ff[5:0];
      buf_ctrl.bit_len = {count_ff, 3'b000};
   end

   md5sd_msgbuf u_msgbuf (
      .clock    (clock),
      .ctrl     (buf_ctrl),
      .msg_word (msg_word)
   );

   md5sd_step u_step (
      .work      (work_ff),
      .msg       (msg_word),
      .step      (step_ff),
      .work_next (step_out)
   );

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      kind_in     = kind_ff;
      fin_pend_in = fin_pend_ff;
      out_idx_in  = out_idx_ff;
      count_in    = count_ff;
      chain_in    = chain_ff;
      work_in     = work_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               count_in = count_new;
               if (req_byte_valid && count_new[5:0] == 6'd0) begin
                  // block full: compress it, pad afterwards if finishing
                  kind_in     = KIND_DATA;
                  fin_pend_in = req_finish;
                  state_in    = S_PREP;
               end else if (req_finish) begin
                  kind_in  = (count_new[5:0] < LEN_POS) ? KIND_PAD_LEN : KIND_PAD_ONLY;
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            work_in  = chain_ff;
            step_in  = 6'd0;
            state_in = S_STEP;
         end
         S_STEP: begin
            work_in = step_out;
            step_in = step_ff + 6'd1;
            if (step_ff == LAST_STEP) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            for (int j = 0; j < 4; j++) begin
               chain_in[j] = chain_ff[j] + work_ff[j];
            end
            case (kind_ff)
               KIND_DATA: begin
                  fin_pend_in = 1'b0;
                  if (fin_pend_ff) begin
                     kind_in  = KIND_PAD_LEN;
                     state_in = S_PREP;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               KIND_PAD_ONLY: begin
                  kind_in  = KIND_LEN_ONLY;
                  state_in = S_PREP;
               end
               default: begin
                  out_idx_in = 2'd0;
                  state_in   = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (rsp_fire) begin
               if (out_idx_ff == LAST_WORD_IDX) begin
                  // drop the message: back to initial chaining and count
                  chain_in = {IV_D, IV_C, IV_B, IV_A};
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 2'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fin_pend_ff <= 1'b0;
         out_idx_ff  <= 2'd0;
         count_ff    <= '0;
         chain_ff    <= {IV_D, IV_C, IV_B, IV_A};
      end else begin
         state_ff    <= state_in;
         fin_pend_ff <= fin_pend_in;
         out_idx_ff  <= out_idx_in;
         count_ff    <= count_in;
         chain_ff    <= chain_in;
      end
   end

   // working registers have no reset; each is set before it is read
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      kind_ff <= kind_in;
      work_ff <= work_in;
   end

   `MD5SD_NEVER(a_req_rsp_excl, req_ready && rsp_valid, "request taken while digest pending")
   `MD5SD_IMPLIES_NEXT(a_count_hold, state_ff == S_STEP, $stable(count_ff), "count moved during compression")
   `MD5SD_IMPLIES(a_out_kind, state_ff == S_OUT, kind_ff == KIND_PAD_LEN || kind_ff == KIND_LEN_ONLY, "digest without length block")
   `MD5SD_IMPLIES_NEXT(a_reinit, rsp_fire && rsp_last_word, state_ff == S_IDLE && count_ff == '0 && chain_ff[0] == IV_A, "no reinit after digest")

endmodule

/* test/tb_md5_stream_digest.sv */
module tb_md5_stream_digest;
   timeunit 1ns;
   timeprecision 1ps;

   // One request word: an optional message byte and the end-of-message flag.
   // hold makes the driver wait until every digest word already owed has come.
   typedef struct {
      logic [7:0] data;
      logic       byte_valid;
      logic       finish;
      bit         hold;
   } req_word_type;

   // One digest word as the response channel should carry it
   typedef struct {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_valid = 1'b0;
   logic        req_finish = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;

   md5_stream_digest i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_byte_valid  (req_byte_valid),
      .req_finish      (req_finish),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // ---------------------------------------------------------------------
   // Digest predictor: its own copy of the chaining words, the 64-byte
   // block being gathered and the running byte count of the message.
   // ---------------------------------------------------------------------
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_MARK = 8'h80;
   localparam int          LEN_OFFSET = 56;

   logic [31:0] step_k [0:63] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };
   int unsigned step_rot [0:15] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   logic [31:0] md5_chain [0:3];
   logic [7:0]  md5_block [0:63];
   logic [60:0] md5_len;

   // Digest words owed by the block, oldest first
   digest_word_type digest_q [$];
   // Request words still to be offered
   req_word_type    req_words_q [$];

   int fail_cnt = 0;
   int n_items = 0;
   bit send_calm = 1'b0;
   bit recv_calm = 1'b1;

   // Start a fresh message: initial chaining words, nothing counted
   task automatic md5_restart();
      md5_chain[0] = INIT_A;
      md5_chain[1] = INIT_B;
      md5_chain[2] = INIT_C;
      md5_chain[3] = INIT_D;
      md5_len = '0;
   endtask

   // Fold the gathered block into the chaining words (64 steps)
   task automatic md5_fold_block();
      logic [31:0] m [0:15];
      logic [31:0] a, b, c, d, f, t, sum;
      int g;
      int unsigned r;
      for (int i = 0; i < 16; i++)
         m[i] = {md5_block[4*i+3], md5_block[4*i+2], md5_block[4*i+1], md5_block[4*i]};
      a = md5_chain[0];
      b = md5_chain[1];
      c = md5_chain[2];
      d = md5_chain[3];
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            f = (b & c) | (~b & d);
            g = i;
         end else if (i < 32) begin
            f = (b & d) | (c & ~d);
            g = (5 * i + 1) & 15;
         end else if (i < 48) begin
            f = b ^ c ^ d;
            g = (3 * i + 5) & 15;
         end else begin
            f = c ^ (b | ~d);
            g = (7 * i) & 15;
         end
         t = d;
         d = c;
         c = b;
         sum = a + f + step_k[i] + m[g];
         r = step_rot[((i >> 4) << 2) | (i & 3)];
         b = b + ((sum << r) | (sum >> (32 - r)));
         a = t;
      end
      md5_chain[0] += a;
      md5_chain[1] += b;
      md5_chain[2] += c;
      md5_chain[3] += d;
   endtask

   // Apply one accepted request word; on finish, pad, append the bit count
   // and queue the four digest words.
   task automatic md5_take_word(input logic [7:0] data, input logic byte_valid,
                                input logic finish);
      logic [63:0]     bit_len;
      int              p;
      digest_word_type dw;
      if (byte_valid) begin
         md5_block[md5_len[5:0]] = data;
         md5_len = md5_len + 61'd1;
         if (md5_len[5:0] == 6'd0)
            md5_fold_block();
      end
      if (finish) begin
         bit_len = {md5_len, 3'b000};
         p = int'(md5_len[5:0]);
         md5_block[p] = PAD_MARK;
         p++;
         // no room left for the length: pad out and spend a whole block on it
         if (p > LEN_OFFSET) begin
            while (p < 64) begin
               md5_block[p] = 8'h00;
               p++;
            end
            md5_fold_block();
            p = 0;
         end
         while (p < LEN_OFFSET) begin
            md5_block[p] = 8'h00;
            p++;
         end
         for (int j = 0; j < 8; j++)
            md5_block[LEN_OFFSET + j] = bit_len[8*j +: 8];
         md5_fold_block();
         for (int j = 0; j < 4; j++) begin
            dw.word  = md5_chain[j];
            dw.index = 2'(j);
            dw.last  = (j == 3);
            digest_q.push_back(dw);
         end
         md5_restart();
      end
   endtask

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %h, want %h", $realtime, what, got, want);
      fail_cnt++;
   endtask

   // Gap before the next word on either side; calm stretches have none
   function automatic int draw_wait(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 16));
   endfunction

   // ---------------------------------------------------------------------
   // Clock and reset
   // ---------------------------------------------------------------------
   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Driver: offer queued request words. Predict on acceptance, then draw
   // a gap; a word marked hold waits until no digest word is owed. Valid is
   // assigned once per edge, so back-to-back words keep it high.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive
      logic         nv;
      req_word_type cur;
      int           gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         nv = req_valid;
         if (req_valid && req_ready) begin
            md5_take_word(req_data_byte, req_byte_valid, req_finish);
            nv = 1'b0;
            if ($urandom_range(0, 24) == 0)
               send_calm = !send_calm;
            gap_left = draw_wait(send_calm);
         end
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_words_q.size() > 0 &&
                         (!req_words_q[0].hold || digest_q.size() == 0)) begin
               cur = req_words_q.pop_front();
               req_data_byte  <= cur.data;
               req_byte_valid <= cur.byte_valid;
               req_finish     <= cur.finish;
               nv = 1'b1;
            end
         end
         req_valid <= nv;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each accepted digest word against the oldest one owed,
   // then stall ready for a drawn number of cycles.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch
      digest_word_type want;
      int              stall_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               report_mismatch("digest word with none owed", rsp_digest_word, 32'h0);
            end else begin
               want = digest_q.pop_front();
               if (rsp_digest_word !== want.word)
                  report_mismatch("digest_word", rsp_digest_word, want.word);
               if (rsp_word_index !== want.index)
                  report_mismatch("word_index", 32'(rsp_word_index), 32'(want.index));
               if (rsp_last_word !== want.last)
                  report_mismatch("last_word", 32'(rsp_last_word), 32'(want.last));
            end
            if ($urandom_range(0, 19) == 0)
               recv_calm = !recv_calm;
            stall_left = draw_wait(recv_calm);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic push_req(input logic [7:0] data, input logic byte_valid,
                           input logic finish, input bit hold);
      req_word_type w;
      w.data = data;
      w.byte_valid = byte_valid;
      w.finish = finish;
      w.hold = hold;
      req_words_q.push_back(w);
      n_items++;
   endtask

   // Queue one message of len random bytes, sprinkled with ignored words.
   // End it either on the last byte or with a separate finish-only word.
   task automatic add_message(input int len, input bit finish_on_byte,
                              input bit hold_first);
      bit hold;
      hold = hold_first;
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 7) == 0) begin
            push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, hold);
            hold = 1'b0;
         end
         push_req(8'($urandom_range(0, 255)), 1'b1,
                  finish_on_byte && (k == len - 1), hold);
         hold = 1'b0;
      end
      if (len == 0 || !finish_on_byte)
         push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, hold);
   endtask

   initial begin : stimulus
      int len;
      int pick;
      md5_restart();

      // empty message: finish with no byte at all
      push_req(8'h00, 1'b0, 1'b1, 1'b0);
      // single byte carrying the finish flag
      push_req(8'h61, 1'b1, 1'b1, 1'b0);
      // ignored byte ahead of real ones, then a finish whose data must be ignored
      push_req(8'hff, 1'b0, 1'b0, 1'b0);
      push_req(8'hff, 1'b1, 1'b0, 1'b0);
      push_req(8'h00, 1'b1, 1'b0, 1'b0);
      push_req(8'h5a, 1'b0, 1'b1, 1'b0);
      // hold off until the block has drained, then a one-byte message
      push_req(8'ha5, 1'b1, 1'b1, 1'b1);

      // 56 bytes: the length no longer fits, so padding takes two blocks
      add_message(56, 1'b0, 1'b1);
      // 64 bytes ending on the byte that fills the block
      add_message(64, 1'b1, 1'b0);

      // mostly short messages, some around the block boundary, a few long
      while (n_items < 220) begin
         pick = $urandom_range(0, 19);
         if (pick < 13)
            len = $urandom_range(0, 8);
         else if (pick < 16)
            len = $urandom_range(9, 40);
         else if (pick < 19)
            len = $urandom_range(54, 66);
         else
            len = $urandom_range(119, 129);
         // trim the last message so the run stays near its word budget
         if (len > 220 - n_items)
            len = 220 - n_items;
         add_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
      end

      // drain: everything offered and accepted, nothing owed, then let the
      // block settle before judging
      @(negedge reset);
      while (req_words_q.size() > 0 || req_valid || digest_q.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_cnt == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Guard against a hang: far beyond the slowest legal run
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/md5sd_pkg.sv
rtl/md5sd_step.sv
rtl/md5sd_msgbuf.sv
rtl/md5_stream_digest.sv
test/tb_md5_stream_digest.sv
